>>> src/vrsm_pkg.sv
// ----------------------------------------------------------------------------
// vrsm_pkg: shared types and constants of the velocity ramp / stall monitor
// Request codes, register indexes, reset values and the structs that travel
// between the register file, the step core and the top level.
// ----------------------------------------------------------------------------
package vrsm_pkg;

  // request types
  localparam logic [2:0] REQ_VELOCITY = 3'd0;
  localparam logic [2:0] REQ_TORQUE   = 3'd1;
  localparam logic [2:0] REQ_ESTOP    = 3'd2;
  localparam logic [2:0] REQ_RAMP_TICK = 3'd3;
  localparam logic [2:0] REQ_STATUS   = 3'd4;
  localparam logic [2:0] REQ_MS_TICK  = 3'd5;

  // register indexes
  localparam logic [2:0] CFG_MAX_VELOCITY     = 3'd0;
  localparam logic [2:0] CFG_MAX_TORQUE       = 3'd1;
  localparam logic [2:0] CFG_RAMP_STEP        = 3'd2;
  localparam logic [2:0] CFG_STALL_MIN_TARGET = 3'd3;
  localparam logic [2:0] CFG_STALL_SETTLE_MS  = 3'd4;
  localparam logic [2:0] CFG_STALL_RATIO_PCT  = 3'd5;
  localparam logic [2:0] CFG_RAMP_ENABLE      = 3'd6;
  localparam logic [2:0] CFG_STALL_ENABLE     = 3'd7;

  // register reset values
  localparam logic [30:0] RST_MAX_VELOCITY     = 31'd100000;
  localparam logic [14:0] RST_MAX_TORQUE       = 15'd2000;
  localparam logic [30:0] RST_RAMP_STEP        = 31'd1000;
  localparam logic [30:0] RST_STALL_MIN_TARGET = 31'd1000;
  localparam logic [19:0] RST_STALL_SETTLE_MS  = 20'd5000;
  localparam logic [6:0]  RST_STALL_RATIO_PCT  = 7'd60;

  typedef struct packed {
    logic [30:0] max_velocity;
    logic [14:0] max_torque;
    logic [30:0] ramp_step;
    logic [30:0] stall_min_target;
    logic [19:0] stall_settle_ms;
    logic [6:0]  stall_ratio_pct;
    logic        ramp_enable;
    logic        stall_enable;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] command_value;
    logic signed [31:0] actual_velocity;
  } item_t;

  typedef struct packed {
    logic               write_velocity;
    logic signed [31:0] velocity_out;
    logic               write_torque;
    logic signed [15:0] torque_out;
    logic               stop_out;
    logic               hold_out;
    logic               stall_detected;
    logic               target_reached;
    logic               clipped;
    logic               monitor_active;
  } result_t;

endpackage

>>> src/vrsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// vrsm_cfg_regs: configuration register file
// Eight registers written by index; write data is truncated to each width.
// ----------------------------------------------------------------------------
module vrsm_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [31:0]         wr_data,
  output vrsm_pkg::cfg_t      cfg
);

  vrsm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_velocity     <= vrsm_pkg::RST_MAX_VELOCITY;
      cfg_r.max_torque       <= vrsm_pkg::RST_MAX_TORQUE;
      cfg_r.ramp_step        <= vrsm_pkg::RST_RAMP_STEP;
      cfg_r.stall_min_target <= vrsm_pkg::RST_STALL_MIN_TARGET;
      cfg_r.stall_settle_ms  <= vrsm_pkg::RST_STALL_SETTLE_MS;
      cfg_r.stall_ratio_pct  <= vrsm_pkg::RST_STALL_RATIO_PCT;
      cfg_r.ramp_enable      <= 1'b1;
      cfg_r.stall_enable     <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        vrsm_pkg::CFG_MAX_VELOCITY:     cfg_r.max_velocity     <= wr_data[30:0];
        vrsm_pkg::CFG_MAX_TORQUE:       cfg_r.max_torque       <= wr_data[14:0];
        vrsm_pkg::CFG_RAMP_STEP:        cfg_r.ramp_step        <= wr_data[30:0];
        vrsm_pkg::CFG_STALL_MIN_TARGET: cfg_r.stall_min_target <= wr_data[30:0];
        vrsm_pkg::CFG_STALL_SETTLE_MS:  cfg_r.stall_settle_ms  <= wr_data[19:0];
        vrsm_pkg::CFG_STALL_RATIO_PCT:  cfg_r.stall_ratio_pct  <= wr_data[6:0];
        vrsm_pkg::CFG_RAMP_ENABLE:      cfg_r.ramp_enable      <= wr_data[0];
        vrsm_pkg::CFG_STALL_ENABLE:     cfg_r.stall_enable     <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/vrsm_core.sv
// ----------------------------------------------------------------------------
// vrsm_core: ramp and stall monitor state with its single-pass step logic
// Holds the ramp and monitor state, computes one result per request and
// updates the state when the request is taken.
// ----------------------------------------------------------------------------
module vrsm_core #(
  parameter int VW  = 32,
  parameter int SCW = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  vrsm_pkg::cfg_t      cfg,
  input  vrsm_pkg::item_t     item,
  output vrsm_pkg::result_t   res
);

  localparam int CW = (SCW > 20) ? SCW : 20;
  localparam logic [33:0] VWMAX = (34'd1 << (VW - 1)) - 34'd1;

  logic signed [VW-1:0]  cv_r, cv_nxt;
  logic signed [VW-1:0]  tgt_r, tgt_nxt;
  logic signed [VW-1:0]  mt_r, mt_nxt;
  logic                  running_r, running_nxt;
  logic                  armed_r, armed_nxt;
  logic                  latch_r, latch_nxt;
  logic [SCW-1:0]        cnt_r, cnt_nxt;

  logic signed [33:0] vlim, cmd_s, vclamp, tlim, tclamp;
  logic signed [33:0] cv_s, tgt_s, step_s, up_s, dn_s, nx_s, mon_v, mon_abs, mt_s;
  logic               vel_hi, vel_lo, tq_hi, tq_lo, at_tgt, low_speed;
  logic signed [32:0] act_s;
  logic [32:0]        act_abs;
  logic [33:0]        mt_abs;
  logic [39:0]        act_inc, lhs, rhs;
  logic               settled, stall_hit;
  logic               do_start;

  // velocity limit is also bounded by the storage width
  assign vlim   = ({3'b0, cfg.max_velocity} < VWMAX) ? {3'b0, cfg.max_velocity} : VWMAX;
  assign cmd_s  = 34'(item.command_value);
  assign vel_hi = cmd_s > vlim;
  assign vel_lo = cmd_s < -vlim;
  assign vclamp = vel_hi ? vlim : (vel_lo ? -vlim : cmd_s);

  assign tlim   = {19'b0, cfg.max_torque};
  assign tq_hi  = cmd_s > tlim;
  assign tq_lo  = cmd_s < -tlim;
  assign tclamp = tq_hi ? tlim : (tq_lo ? -tlim : cmd_s);

  // one ramp step, never past the target
  assign cv_s   = 34'(cv_r);
  assign tgt_s  = 34'(tgt_r);
  assign step_s = {3'b0, cfg.ramp_step};
  assign up_s   = cv_s + step_s;
  assign dn_s   = cv_s - step_s;
  assign at_tgt = cv_r == tgt_r;
  assign nx_s   = (cv_s < tgt_s) ? ((up_s > tgt_s) ? tgt_s : up_s)
                                 : ((dn_s < tgt_s) ? tgt_s : dn_s);

  assign mon_v     = (item.req_type == vrsm_pkg::REQ_VELOCITY) ? vclamp
                                                               : (at_tgt ? cv_s : nx_s);
  assign mon_abs   = mon_v[33] ? -mon_v : mon_v;
  assign low_speed = mon_abs < {3'b0, cfg.stall_min_target};

  // |act| < round(|mt| * pct / 100)  <=>  100 * (|act| + 1) <= |mt| * pct + 50
  assign act_s   = 33'(item.actual_velocity);
  assign act_abs = act_s[32] ? 33'(-act_s) : 33'(act_s);
  assign act_inc = 40'(act_abs) + 40'd1;
  assign lhs     = (act_inc << 6) + (act_inc << 5) + (act_inc << 2);
  assign mt_s    = 34'(mt_r);
  assign mt_abs  = mt_s[33] ? 34'(-mt_s) : 34'(mt_s);
  assign rhs     = 40'(mt_abs[31:0]) * 40'(cfg.stall_ratio_pct) + 40'd50;
  assign stall_hit = lhs <= rhs;
  assign settled = CW'(cnt_r) >= CW'(cfg.stall_settle_ms);

  always_comb begin
    cv_nxt      = cv_r;
    tgt_nxt     = tgt_r;
    mt_nxt      = mt_r;
    running_nxt = running_r;
    armed_nxt   = armed_r;
    latch_nxt   = latch_r;
    cnt_nxt     = cnt_r;
    do_start    = 1'b0;
    res         = '0;

    unique case (item.req_type)
      vrsm_pkg::REQ_VELOCITY: begin
        res.clipped = vel_hi | vel_lo;
        armed_nxt   = 1'b0;
        latch_nxt   = 1'b0;
        mt_nxt      = '0;
        if (cfg.ramp_enable) begin
          tgt_nxt     = vclamp[VW-1:0];
          running_nxt = 1'b1;
        end else begin
          cv_nxt             = vclamp[VW-1:0];
          tgt_nxt            = '0;
          running_nxt        = 1'b0;
          res.write_velocity = 1'b1;
          res.velocity_out   = vclamp[31:0];
          res.target_reached = 1'b1;
          do_start           = 1'b1;
        end
      end
      vrsm_pkg::REQ_TORQUE: begin
        cv_nxt           = '0;
        tgt_nxt          = '0;
        running_nxt      = 1'b0;
        armed_nxt        = 1'b0;
        latch_nxt        = 1'b0;
        mt_nxt           = '0;
        res.clipped      = tq_hi | tq_lo;
        res.write_torque = 1'b1;
        res.torque_out   = tclamp[15:0];
      end
      vrsm_pkg::REQ_ESTOP: begin
        cv_nxt       = '0;
        tgt_nxt      = '0;
        running_nxt  = 1'b0;
        armed_nxt    = 1'b0;
        latch_nxt    = 1'b0;
        mt_nxt       = '0;
        res.stop_out = 1'b1;
      end
      vrsm_pkg::REQ_RAMP_TICK: begin
        if (running_r) begin
          if (at_tgt) begin
            running_nxt        = 1'b0;
            res.target_reached = 1'b1;
            do_start           = 1'b1;
          end else begin
            cv_nxt             = nx_s[VW-1:0];
            res.write_velocity = 1'b1;
            res.velocity_out   = nx_s[31:0];
            if (nx_s == tgt_s) begin
              running_nxt        = 1'b0;
              res.target_reached = 1'b1;
              do_start           = 1'b1;
            end
          end
        end
      end
      vrsm_pkg::REQ_STATUS: begin
        if (cfg.stall_enable && armed_r && !latch_r && settled && stall_hit) begin
          latch_nxt    = 1'b1;
          armed_nxt    = 1'b0;
          cv_nxt       = '0;
          tgt_nxt      = '0;
          running_nxt  = 1'b0;
          res.hold_out = 1'b1;
        end
      end
      vrsm_pkg::REQ_MS_TICK: begin
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + SCW'(1);
        end
      end
      default: ;
    endcase

    // arm (or disarm below the minimum speed) once the target is reached
    if (do_start && cfg.stall_enable) begin
      latch_nxt = 1'b0;
      if (low_speed) begin
        armed_nxt = 1'b0;
        mt_nxt    = '0;
      end else begin
        armed_nxt = 1'b1;
        mt_nxt    = mon_v[VW-1:0];
        cnt_nxt   = '0;
      end
    end

    res.stall_detected = latch_nxt;
    res.monitor_active = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r      <= '0;
      tgt_r     <= '0;
      mt_r      <= '0;
      running_r <= 1'b0;
      armed_r   <= 1'b0;
      latch_r   <= 1'b0;
      cnt_r     <= '0;
    end else if (en) begin
      cv_r      <= cv_nxt;
      tgt_r     <= tgt_nxt;
      mt_r      <= mt_nxt;
      running_r <= running_nxt;
      armed_r   <= armed_nxt;
      latch_r   <= latch_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

>>> src/velocity_ramp_with_stall_monitor_unit.sv
// ----------------------------------------------------------------------------
// velocity_ramp_with_stall_monitor_unit: velocity ramp with stall monitor
// Input register, single-pass step core and result register.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_stall    req_type, command_value, actual_velocity
//   out_      output     out_valid / out_stall  write/velocity/torque/stop/hold/flags
//   cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle while out_stall is low; each request passes both registers.
// The step core updates its state in the cycle a request leaves the input
// register. rst_n is synchronous and clears state, config registers and valids.
// out_stall holds the result register, then the input register, then in_stall.
// in_stall is high and cfg_ready is low while rst_n is low; cfg_ready is
// otherwise always high.
// ----------------------------------------------------------------------------
module velocity_ramp_with_stall_monitor_unit #(
  parameter int VELOCITY_WIDTH       = 32,
  parameter int SETTLE_COUNTER_WIDTH = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_command_value,
  input  logic signed [31:0] in_actual_velocity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_write_velocity,
  output logic signed [31:0] out_velocity_out,
  output logic               out_write_torque,
  output logic signed [15:0] out_torque_out,
  output logic               out_stop_out,
  output logic               out_hold_out,
  output logic               out_stall_detected,
  output logic               out_target_reached,
  output logic               out_clipped,
  output logic               out_monitor_active,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  vrsm_pkg::cfg_t    cfg;
  vrsm_pkg::item_t   item_r;
  vrsm_pkg::result_t res, res_r;
  logic              in_valid_r, out_valid_r;
  logic              adv, fire, in_load;

  assign cfg_ready = rst_n;

  vrsm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv     = !out_valid_r || !out_stall;
  assign fire    = in_valid_r && adv;
  assign in_load = !in_valid_r || adv;
  assign in_stall = !rst_n || !in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      item_r.req_type        <= in_req_type;
      item_r.command_value   <= in_command_value;
      item_r.actual_velocity <= in_actual_velocity;
    end
  end

  vrsm_core #(
    .VW  (VELOCITY_WIDTH),
    .SCW (SETTLE_COUNTER_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (fire),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_write_velocity = res_r.write_velocity;
  assign out_velocity_out   = res_r.velocity_out;
  assign out_write_torque   = res_r.write_torque;
  assign out_torque_out     = res_r.torque_out;
  assign out_stop_out       = res_r.stop_out;
  assign out_hold_out       = res_r.hold_out;
  assign out_stall_detected = res_r.stall_detected;
  assign out_target_reached = res_r.target_reached;
  assign out_clipped        = res_r.clipped;
  assign out_monitor_active = res_r.monitor_active;

endmodule

>>> sim/tb_velocity_ramp_with_stall_monitor_unit.sv
// ----------------------------------------------------------------------------
// tb_velocity_ramp_with_stall_monitor_unit: self-checking bench for the ramp
// Drives requests and register writes, predicts every result with a local
// model of the ramp, torque clamp and stall monitor, and compares each result
// field by field in order. Directed table first, then random motion sequences
// under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_velocity_ramp_with_stall_monitor_unit;

  localparam int         TIMEOUT_CYCLES    = 200000;
  localparam int         ITEMS_PER_SETTING = 125;
  localparam longint     VEL_LIMIT         = 64'sd2147483647;
  localparam longint     SETTLE_MAX        = 64'sd1048575;
  localparam logic [2:0] REQ_SPARE_A       = 3'd6;
  localparam logic [2:0] REQ_SPARE_B       = 3'd7;

  typedef struct {
    bit                bit_is_cfg_unused;
    bit                is_cfg;
    logic [2:0]        code;
    logic [31:0]       val;
    vrsm_pkg::item_t   req;
    bit                pinned;
    vrsm_pkg::result_t res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_req_type = '0;
  logic signed [31:0] in_command_value = '0;
  logic signed [31:0] in_actual_velocity = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_write_velocity;
  logic signed [31:0] out_velocity_out;
  logic               out_write_torque;
  logic signed [15:0] out_torque_out;
  logic               out_stop_out;
  logic               out_hold_out;
  logic               out_stall_detected;
  logic               out_target_reached;
  logic               out_clipped;
  logic               out_monitor_active;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // pinned expectation travels with the request it belongs to
  bit                req_pinned = 1'b0;
  vrsm_pkg::result_t req_pinned_res = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;

  vrsm_pkg::result_t pending_results[$];
  dir_row_t          directed_rows[$];

  // local copy of the block's state and registers
  vrsm_pkg::cfg_t model_cfg;
  longint cmd_vel = 0;
  longint vel_goal = 0;
  bit     ramp_active = 1'b0;
  bit     mon_armed = 1'b0;
  bit     stall_seen = 1'b0;
  longint mon_ref = 0;
  longint settle_ticks = 0;

  velocity_ramp_with_stall_monitor_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_command_value   (in_command_value),
    .in_actual_velocity (in_actual_velocity),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_velocity (out_write_velocity),
    .out_velocity_out   (out_velocity_out),
    .out_write_torque   (out_write_torque),
    .out_torque_out     (out_torque_out),
    .out_stop_out       (out_stop_out),
    .out_hold_out       (out_hold_out),
    .out_stall_detected (out_stall_detected),
    .out_target_reached (out_target_reached),
    .out_clipped        (out_clipped),
    .out_monitor_active (out_monitor_active),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- model
  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim, inout bit clip);
    if (v > lim) begin
      clip = 1'b1;
      return lim;
    end
    if (v < -lim) begin
      clip = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  function void clear_ramp();
    cmd_vel = 0;
    vel_goal = 0;
    ramp_active = 1'b0;
  endfunction

  function void drop_monitor();
    mon_armed = 1'b0;
    stall_seen = 1'b0;
    mon_ref = 0;
  endfunction

  function void arm_monitor(input longint v);
    if (!model_cfg.stall_enable) return;
    if (mag(v) < longint'(model_cfg.stall_min_target)) begin
      drop_monitor();
      return;
    end
    mon_armed = 1'b1;
    stall_seen = 1'b0;
    mon_ref = v;
    settle_ticks = 0;
  endfunction

  // round-half-up percentage of the monitored target
  function longint stall_threshold();
    return (mag(mon_ref) * longint'(model_cfg.stall_ratio_pct) + 50) / 100;
  endfunction

  function void predict_motion_step(input vrsm_pkg::item_t req,
                                    output vrsm_pkg::result_t r);
    longint cmdv, act, v, nx, vlim, tq, vout;
    bit     clip, wv, wt, stop, hold, reached;
    cmdv = longint'($signed(req.command_value));
    act = longint'($signed(req.actual_velocity));
    {clip, wv, wt, stop, hold, reached} = '0;
    vout = 0;
    tq = 0;
    vlim = longint'(model_cfg.max_velocity);
    if (vlim > VEL_LIMIT) vlim = VEL_LIMIT;
    case (req.req_type)
      vrsm_pkg::REQ_VELOCITY: begin
        v = clamp_sym(cmdv, vlim, clip);
        drop_monitor();
        if (model_cfg.ramp_enable) begin
          vel_goal = v;
          ramp_active = 1'b1;
        end else begin
          clear_ramp();
          wv = 1'b1;
          vout = v;
          cmd_vel = v;
          reached = 1'b1;
          arm_monitor(v);
        end
      end
      vrsm_pkg::REQ_TORQUE: begin
        clear_ramp();
        drop_monitor();
        tq = clamp_sym(cmdv, longint'(model_cfg.max_torque), clip);
        wt = 1'b1;
      end
      vrsm_pkg::REQ_ESTOP: begin
        clear_ramp();
        drop_monitor();
        stop = 1'b1;
      end
      vrsm_pkg::REQ_RAMP_TICK: begin
        if (ramp_active) begin
          if (cmd_vel == vel_goal) begin
            ramp_active = 1'b0;
            arm_monitor(cmd_vel);
            reached = 1'b1;
          end else begin
            nx = cmd_vel;
            if (cmd_vel < vel_goal) begin
              nx += longint'(model_cfg.ramp_step);
              if (nx > vel_goal) nx = vel_goal;
            end else begin
              nx -= longint'(model_cfg.ramp_step);
              if (nx < vel_goal) nx = vel_goal;
            end
            wv = 1'b1;
            vout = nx;
            cmd_vel = nx;
            if (nx == vel_goal) begin
              ramp_active = 1'b0;
              arm_monitor(nx);
              reached = 1'b1;
            end
          end
        end
      end
      vrsm_pkg::REQ_STATUS: begin
        if (model_cfg.stall_enable && mon_armed && !stall_seen &&
            settle_ticks >= longint'(model_cfg.stall_settle_ms)) begin
          if (mag(act) < stall_threshold()) begin
            stall_seen = 1'b1;
            mon_armed = 1'b0;
            clear_ramp();
            hold = 1'b1;
          end
        end
      end
      vrsm_pkg::REQ_MS_TICK: begin
        if (settle_ticks < SETTLE_MAX) settle_ticks++;
      end
      default: ;
    endcase
    r.write_velocity = wv;
    r.velocity_out = vout[31:0];
    r.write_torque = wt;
    r.torque_out = tq[15:0];
    r.stop_out = stop;
    r.hold_out = hold;
    r.stall_detected = stall_seen;
    r.target_reached = reached;
    r.clipped = clip;
    r.monitor_active = mon_armed;
  endfunction

  // ------------------------------------------------------------ checking
  function automatic string fmt_result(input vrsm_pkg::result_t r);
    return {$sformatf("wv=%0d v=%0d wt=%0d t=%0d stop=%0d hold=%0d ",
                      r.write_velocity, r.velocity_out, r.write_torque, r.torque_out,
                      r.stop_out, r.hold_out),
            $sformatf("stall=%0d reach=%0d clip=%0d mon=%0d",
                      r.stall_detected, r.target_reached, r.clipped, r.monitor_active)};
  endfunction

  function void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %s", msg);
  endfunction

  always @(posedge clk) begin : scoreboard
    vrsm_pkg::item_t   req;
    vrsm_pkg::result_t exp_r, got;
    string             bad;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        req = {in_req_type, in_command_value, in_actual_velocity};
        predict_motion_step(req, exp_r);
        pending_results.push_back(req_pinned ? req_pinned_res : exp_r);
      end
      if (out_valid && !out_stall) begin
        got = {out_write_velocity, out_velocity_out, out_write_torque, out_torque_out,
               out_stop_out, out_hold_out, out_stall_detected, out_target_reached,
               out_clipped, out_monitor_active};
        results_seen++;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result %0d with nothing expected: %s",
                                  results_seen, fmt_result(got)));
        end else begin
          exp_r = pending_results.pop_front();
          bad = "";
          if (got.write_velocity !== exp_r.write_velocity) bad = {bad, " write_velocity"};
          if (got.velocity_out !== exp_r.velocity_out) bad = {bad, " velocity_out"};
          if (got.write_torque !== exp_r.write_torque) bad = {bad, " write_torque"};
          if (got.torque_out !== exp_r.torque_out) bad = {bad, " torque_out"};
          if (got.stop_out !== exp_r.stop_out) bad = {bad, " stop_out"};
          if (got.hold_out !== exp_r.hold_out) bad = {bad, " hold_out"};
          if (got.stall_detected !== exp_r.stall_detected) bad = {bad, " stall_detected"};
          if (got.target_reached !== exp_r.target_reached) bad = {bad, " target_reached"};
          if (got.clipped !== exp_r.clipped) bad = {bad, " clipped"};
          if (got.monitor_active !== exp_r.monitor_active) bad = {bad, " monitor_active"};
          if (bad.len() != 0)
            note_mismatch($sformatf("result %0d:%s\n  exp %s\n  got %s", results_seen, bad,
                                    fmt_result(exp_r), fmt_result(got)));
        end
      end
    end
  end

  // ------------------------------------------------------------- driving
  function automatic vrsm_pkg::item_t rand_item(input logic [2:0] kind);
    vrsm_pkg::item_t req;
    req.req_type = kind;
    req.command_value = $urandom;
    req.actual_velocity = $urandom;
    return req;
  endfunction

  function automatic vrsm_pkg::result_t plain_result(input bit wt,
                                                     input logic signed [15:0] tq,
                                                     input bit stop, input bit clip);
    vrsm_pkg::result_t r;
    r = '0;
    r.write_torque = wt;
    r.torque_out = tq;
    r.stop_out = stop;
    r.clipped = clip;
    return r;
  endfunction

  function void add_item(input logic [2:0] kind, input logic [31:0] cmd,
                         input logic [31:0] act, input bit pinned,
                         input vrsm_pkg::result_t res);
    dir_row_t row;
    row.bit_is_cfg_unused = 1'b0;
    row.is_cfg = 1'b0;
    row.code = '0;
    row.val = '0;
    row.req.req_type = kind;
    row.req.command_value = cmd;
    row.req.actual_velocity = act;
    row.pinned = pinned;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  function void add_cfg(input logic [2:0] idx, input logic [31:0] val);
    dir_row_t row;
    row = '{bit_is_cfg_unused: 1'b0, is_cfg: 1'b1, code: idx, val: val, req: '0,
            pinned: 1'b0, res: '0};
    directed_rows.push_back(row);
  endfunction

  // called and returns at a falling edge
  task automatic send_request(input vrsm_pkg::item_t req, input bit pinned,
                              input vrsm_pkg::result_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req.req_type;
    in_command_value <= req.command_value;
    in_actual_velocity <= req.actual_velocity;
    req_pinned <= pinned;
    req_pinned_res <= res;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // unused data bits are random on one write in three; the register keeps its width
  task automatic write_reg(input logic [2:0] idx, input longint val);
    logic [31:0] data;
    int          w;
    case (idx) inside
      vrsm_pkg::CFG_MAX_TORQUE:      w = 15;
      vrsm_pkg::CFG_STALL_SETTLE_MS: w = 20;
      vrsm_pkg::CFG_STALL_RATIO_PCT: w = 7;
      vrsm_pkg::CFG_RAMP_ENABLE, vrsm_pkg::CFG_STALL_ENABLE: w = 1;
      default:                       w = 31;
    endcase
    data = val[31:0];
    if ($urandom_range(0, 2) == 0) data = data | ($urandom << w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vrsm_pkg::CFG_MAX_VELOCITY:     model_cfg.max_velocity = data[30:0];
      vrsm_pkg::CFG_MAX_TORQUE:       model_cfg.max_torque = data[14:0];
      vrsm_pkg::CFG_RAMP_STEP:        model_cfg.ramp_step = data[30:0];
      vrsm_pkg::CFG_STALL_MIN_TARGET: model_cfg.stall_min_target = data[30:0];
      vrsm_pkg::CFG_STALL_SETTLE_MS:  model_cfg.stall_settle_ms = data[19:0];
      vrsm_pkg::CFG_STALL_RATIO_PCT:  model_cfg.stall_ratio_pct = data[6:0];
      vrsm_pkg::CFG_RAMP_ENABLE:      model_cfg.ramp_enable = data[0];
      vrsm_pkg::CFG_STALL_ENABLE:     model_cfg.stall_enable = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    vrsm_pkg::item_t req;
    longint          v, vl, a, thr;
    longint          vals [8];
    int              setting, n, m, target_items;

    model_cfg.max_velocity = vrsm_pkg::RST_MAX_VELOCITY;
    model_cfg.max_torque = vrsm_pkg::RST_MAX_TORQUE;
    model_cfg.ramp_step = vrsm_pkg::RST_RAMP_STEP;
    model_cfg.stall_min_target = vrsm_pkg::RST_STALL_MIN_TARGET;
    model_cfg.stall_settle_ms = vrsm_pkg::RST_STALL_SETTLE_MS;
    model_cfg.stall_ratio_pct = vrsm_pkg::RST_STALL_RATIO_PCT;
    model_cfg.ramp_enable = 1'b1;
    model_cfg.stall_enable = 1'b1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset values of the registers hold for the first rows
    add_item(vrsm_pkg::REQ_RAMP_TICK, 32'd0, 32'd0, 1'b1, '0);
    add_item(REQ_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
    add_item(REQ_SPARE_B, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '0);
    add_item(vrsm_pkg::REQ_TORQUE, 32'h7FFF_FFFF, 32'd0, 1'b1,
             plain_result(1'b1, 16'sd2000, 1'b0, 1'b1));
    add_item(vrsm_pkg::REQ_TORQUE, 32'h8000_0000, 32'd0, 1'b1,
             plain_result(1'b1, -16'sd2000, 1'b0, 1'b1));
    add_item(vrsm_pkg::REQ_TORQUE, -32'sd1234, 32'd0, 1'b1,
             plain_result(1'b1, -16'sd1234, 1'b0, 1'b0));
    add_item(vrsm_pkg::REQ_ESTOP, 32'd0, 32'd0, 1'b1,
             plain_result(1'b0, 16'sd0, 1'b1, 1'b0));
    add_item(vrsm_pkg::REQ_VELOCITY, 32'h7FFF_FFFF, 32'd0, 1'b1,
             plain_result(1'b0, 16'sd0, 1'b0, 1'b1));
    add_item(vrsm_pkg::REQ_ESTOP, 32'd0, 32'd0, 1'b1,
             plain_result(1'b0, 16'sd0, 1'b1, 1'b0));
    add_cfg(vrsm_pkg::CFG_STALL_SETTLE_MS, 32'd0);
    // ramp to 2500 in three steps, one more tick at target, then a stall
    add_item(vrsm_pkg::REQ_VELOCITY, 32'd2500, 32'd0, 1'b0, '0);
    repeat (4) add_item(vrsm_pkg::REQ_RAMP_TICK, 32'd0, 32'd0, 1'b0, '0);
    add_item(vrsm_pkg::REQ_STATUS, 32'd0, 32'd1500, 1'b0, '0);
    add_item(vrsm_pkg::REQ_STATUS, 32'd0, -32'sd1499, 1'b0, '0);
    add_item(vrsm_pkg::REQ_MS_TICK, 32'd0, 32'd0, 1'b0, '0);
    // target below the arming floor
    add_item(vrsm_pkg::REQ_VELOCITY, -32'sd500, 32'd0, 1'b0, '0);
    add_item(vrsm_pkg::REQ_RAMP_TICK, 32'd0, 32'd0, 1'b0, '0);
    add_cfg(vrsm_pkg::CFG_RAMP_ENABLE, 32'd0);
    add_item(vrsm_pkg::REQ_VELOCITY, 32'h8000_0000, 32'd0, 1'b0, '0);
    add_item(vrsm_pkg::REQ_STATUS, 32'd0, 32'h8000_0000, 1'b0, '0);
    add_item(vrsm_pkg::REQ_STATUS, 32'd0, 32'd0, 1'b0, '0);
    add_cfg(vrsm_pkg::CFG_STALL_ENABLE, 32'd0);
    add_cfg(vrsm_pkg::CFG_STALL_RATIO_PCT, 32'd127);
    add_item(vrsm_pkg::REQ_VELOCITY, 32'd5000, 32'd0, 1'b0, '0);
    add_item(vrsm_pkg::REQ_STATUS, 32'd0, 32'd0, 1'b0, '0);

    send_idle_pct = 25;
    recv_stall_pct = 75;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_results();
        write_reg(directed_rows[i].code, longint'(directed_rows[i].val));
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].res);
      end
    end

    for (setting = 0; setting < 6; setting++) begin
      send_idle_pct = (setting < 2) ? 25 : (setting < 4) ? 75 : 0;
      recv_stall_pct = (setting < 2) ? 75 : (setting < 4) ? 25 : 0;
      drain_results();
      case (setting)
        0: begin
          vals[vrsm_pkg::CFG_RAMP_STEP] = $urandom_range(1, 5000);
          vals[vrsm_pkg::CFG_MAX_VELOCITY] =
            vals[vrsm_pkg::CFG_RAMP_STEP] * $urandom_range(1, 8);
          vals[vrsm_pkg::CFG_MAX_TORQUE] = $urandom_range(0, 32767);
          vals[vrsm_pkg::CFG_STALL_MIN_TARGET] =
            $urandom_range(0, vals[vrsm_pkg::CFG_MAX_VELOCITY]);
          vals[vrsm_pkg::CFG_STALL_SETTLE_MS] = $urandom_range(0, 4);
          vals[vrsm_pkg::CFG_STALL_RATIO_PCT] = $urandom_range(1, 100);
          vals[vrsm_pkg::CFG_RAMP_ENABLE] = 1;
          vals[vrsm_pkg::CFG_STALL_ENABLE] = 1;
        end
        1: begin
          vals[vrsm_pkg::CFG_MAX_VELOCITY] = 64'h7FFF_FFFF;
          vals[vrsm_pkg::CFG_MAX_TORQUE] = 32767;
          vals[vrsm_pkg::CFG_RAMP_STEP] = 64'h7FFF_FFFF;
          vals[vrsm_pkg::CFG_STALL_MIN_TARGET] = 0;
          vals[vrsm_pkg::CFG_STALL_SETTLE_MS] = 0;
          vals[vrsm_pkg::CFG_STALL_RATIO_PCT] = 127;
          vals[vrsm_pkg::CFG_RAMP_ENABLE] = 1;
          vals[vrsm_pkg::CFG_STALL_ENABLE] = 1;
        end
        2: begin
          vals[vrsm_pkg::CFG_MAX_VELOCITY] = 0;
          vals[vrsm_pkg::CFG_MAX_TORQUE] = 0;
          vals[vrsm_pkg::CFG_RAMP_STEP] = 1;
          vals[vrsm_pkg::CFG_STALL_MIN_TARGET] = 64'h7FFF_FFFF;
          vals[vrsm_pkg::CFG_STALL_SETTLE_MS] = SETTLE_MAX;
          vals[vrsm_pkg::CFG_STALL_RATIO_PCT] = 0;
          vals[vrsm_pkg::CFG_RAMP_ENABLE] = 0;
          vals[vrsm_pkg::CFG_STALL_ENABLE] = 1;
        end
        3: begin
          vals[vrsm_pkg::CFG_MAX_VELOCITY] = $urandom_range(1, 1000000);
          vals[vrsm_pkg::CFG_MAX_TORQUE] = $urandom_range(0, 32767);
          vals[vrsm_pkg::CFG_RAMP_STEP] = $urandom_range(1, 1000000);
          vals[vrsm_pkg::CFG_STALL_MIN_TARGET] =
            $urandom_range(0, vals[vrsm_pkg::CFG_MAX_VELOCITY] / 2);
          vals[vrsm_pkg::CFG_STALL_SETTLE_MS] = $urandom_range(0, 3);
          vals[vrsm_pkg::CFG_STALL_RATIO_PCT] = 100;
          vals[vrsm_pkg::CFG_RAMP_ENABLE] = 0;
          vals[vrsm_pkg::CFG_STALL_ENABLE] = 1;
        end
        4: begin
          // zero step: the ramp only reaches a target that it already stands at
          vals[vrsm_pkg::CFG_MAX_VELOCITY] = $urandom_range(1, 100000);
          vals[vrsm_pkg::CFG_MAX_TORQUE] = $urandom_range(0, 32767);
          vals[vrsm_pkg::CFG_RAMP_STEP] = 0;
          vals[vrsm_pkg::CFG_STALL_MIN_TARGET] = 0;
          vals[vrsm_pkg::CFG_STALL_SETTLE_MS] = 1;
          vals[vrsm_pkg::CFG_STALL_RATIO_PCT] = 50;
          vals[vrsm_pkg::CFG_RAMP_ENABLE] = 1;
          vals[vrsm_pkg::CFG_STALL_ENABLE] = 0;
        end
        default: begin
          vals[vrsm_pkg::CFG_MAX_VELOCITY] = $urandom_range(0, 32'h7FFF_FFFE);
          vals[vrsm_pkg::CFG_MAX_TORQUE] = $urandom_range(0, 32767);
          vals[vrsm_pkg::CFG_RAMP_STEP] =
            vals[vrsm_pkg::CFG_MAX_VELOCITY] / $urandom_range(1, 10) + 1;
          vals[vrsm_pkg::CFG_STALL_MIN_TARGET] =
            $urandom_range(0, vals[vrsm_pkg::CFG_MAX_VELOCITY]);
          vals[vrsm_pkg::CFG_STALL_SETTLE_MS] = $urandom_range(0, 6);
          vals[vrsm_pkg::CFG_STALL_RATIO_PCT] = $urandom_range(0, 127);
          vals[vrsm_pkg::CFG_RAMP_ENABLE] = $urandom_range(0, 1);
          vals[vrsm_pkg::CFG_STALL_ENABLE] = 1;
        end
      endcase
      for (n = 0; n < 8; n++) write_reg(n[2:0], vals[n]);

      target_items = items_sent + ITEMS_PER_SETTING;
      while (items_sent < target_items) begin
        if ($urandom_range(0, 99) < 30) begin
          send_request(rand_item(3'($urandom_range(0, 7))), 1'b0, '0);
        end else begin
          // velocity request, ramp to target, settle, then probe for a stall
          vl = longint'(model_cfg.max_velocity);
          case ($urandom_range(0, 7))
            0: v = vl;
            1: v = -vl;
            2: v = vl + 1;
            3: v = -vl - 1;
            4: v = longint'($signed($urandom));
            default: begin
              v = longint'($urandom_range(0, vl));
              if ($urandom_range(0, 1) == 1) v = -v;
            end
          endcase
          req = rand_item(vrsm_pkg::REQ_VELOCITY);
          req.command_value = v[31:0];
          send_request(req, 1'b0, '0);
          n = 0;
          while (ramp_active && n < 20) begin
            send_request(rand_item(vrsm_pkg::REQ_RAMP_TICK), 1'b0, '0);
            n++;
          end
          if ($urandom_range(0, 3) == 0)
            send_request(rand_item(vrsm_pkg::REQ_RAMP_TICK), 1'b0, '0);
          m = (model_cfg.stall_settle_ms <= 8) ?
              int'(model_cfg.stall_settle_ms) + $urandom_range(0, 2) : $urandom_range(0, 4);
          repeat (m) send_request(rand_item(vrsm_pkg::REQ_MS_TICK), 1'b0, '0);
          repeat ($urandom_range(1, 3)) begin
            thr = stall_threshold();
            case ($urandom_range(0, 4))
              0: a = thr;
              1: a = thr - 1;
              2: a = 0;
              3: a = 1 - thr;
              default: a = longint'($signed($urandom));
            endcase
            req = rand_item(vrsm_pkg::REQ_STATUS);
            req.actual_velocity = a[31:0];
            send_request(req, 1'b0, '0);
          end
        end
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
